// ===== rtl/core/trse_pkg.sv =====
// shared types, codes and constants of the tagged record store engine
`default_nettype none
package trse_pkg;

	localparam int DEF_COPY_BYTES = 512;

	localparam logic [31:0] HEAD_SIG = 32'h5a2d2fa5;
	localparam logic [31:0] SUM_SIG  = 32'ha3041767;
	localparam logic [31:0] TAIL_SIG = 32'hdd28bf64;

	typedef enum logic [2:0] {
		OP_RAW_WRITE = 3'd0,
		OP_RAW_READ  = 3'd1,
		OP_VALIDATE  = 3'd2,
		OP_RESET     = 3'd3,
		OP_SET_BEGIN = 3'd4,
		OP_SET_DATA  = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_BAD_TAG  = 3'd1,
		ST_NO_SPACE = 3'd2,
		ST_EMPTIED  = 3'd3,
		ST_SEQ_ERR  = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		FROM_FIRST  = 2'd0,
		FROM_SECOND = 2'd1,
		FROM_NONE   = 2'd2
	} from_t;

	typedef enum logic [2:0] {
		SUM_HOLD,
		SUM_LOAD_ZERO,
		SUM_LOAD_SIG,
		SUM_ADD,
		SUM_SUB
	} sum_op_t;

	typedef struct packed {
		sum_op_t    op;
		logic [1:0] lane;
		logic [7:0] data;
	} sum_ctrl_t;

	typedef enum logic [4:0] {
		S_IDLE, S_MOD, S_RAW, S_RAW_WAIT,
		S_V_RD, S_V_CHK, S_V_DEC,
		S_CLR, S_HDR0, S_HDR1, S_SD,
		S_SC_TOP, S_SC_TAG, S_SC_LEN, S_MV_RD, S_MV_WR, S_SB_END,
		S_SEAL_HEAD, S_SUM_RD, S_SUM_ACC, S_SEAL_SUM, S_SEAL_TAIL,
		S_CP_RD, S_CP_WR, S_FIN, S_DONE
	} state_t;

	function automatic logic [7:0] sig_byte(input logic [31:0] w, input logic [1:0] k);
		return w[{k, 3'b000} +: 8];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/trse_store.sv =====
// byte store holding both copies, one write and one registered read port
`default_nettype none
module trse_store #(
	parameter int DEPTH = 1024,
	parameter int AW = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic [7:0]         rdata
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/trse_sum.sv =====
// shared 32-bit checksum accumulator, one byte lane per cycle
`default_nettype none
module trse_sum import trse_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire sum_ctrl_t ctrl,
	output logic [31:0]    acc
);
	logic [31:0] acc_q;
	logic [31:0] term;

	assign term = {24'b0, ctrl.data} << {ctrl.lane, 3'b000};
	assign acc = acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else begin
			case (ctrl.op)
				SUM_LOAD_ZERO: acc_q <= '0;
				SUM_LOAD_SIG:  acc_q <= SUM_SIG;
				SUM_ADD:       acc_q <= acc_q + term;
				SUM_SUB:       acc_q <= acc_q - term;
				default:       acc_q <= acc_q;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/tagged_record_store_engine.sv =====
// top level: sequencer of the duplicated tagged record store
//
// One word in gives one word out. The block takes one word at a time and walks
// the store through its byte-wide write and read ports (address, then registered
// data). Raw write and read first fold the address into the store. Reset does a
// zero fill, a checksum pass and a mirror copy; set data does the checksum pass
// and mirror copy; validate reads the copies, and empties the store when both
// are bad; set begin adds two scans of the record area. A result waits in an
// output register, so the next word may enter meanwhile.
`default_nettype none
module tagged_record_store_engine import trse_pkg::*; #(
	parameter int COPY_BYTES = DEF_COPY_BYTES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// byte_address[9:0], record_tag[17:10], record_length[25:18], data_byte[33:26]
	input  wire logic [39:0] s_tdata,
	// opcode[2:0]
	input  wire logic [2:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// read_byte[7:0], status[10:8], repaired_from[12:11]
	output logic [15:0]      m_tdata
);
	localparam int STORE_BYTES = 2 * COPY_BYTES;
	localparam int AREA_LEN = COPY_BYTES - 12;
	localparam int MW = $clog2(STORE_BYTES);
	localparam int CW = $clog2(COPY_BYTES) + 1;
	localparam int SW = CW + 1;
	localparam int AWX = (MW + 1 > 10) ? MW + 1 : 10;
	localparam int LW = ((CW > 9) ? CW : 9) + 1;
	localparam int WPW = (CW > 10) ? CW : 10;
	localparam int SUM_END = 8 + 4 * ((COPY_BYTES - 12) / 4);
	localparam int CHK_END = 4 + 4 * ((COPY_BYTES - 8) / 4);

	localparam logic [CW-1:0] COPY_C = CW'(COPY_BYTES);
	localparam logic [CW-1:0] AREA_C = CW'(AREA_LEN);
	localparam logic [CW-1:0] SUM_END_C = CW'(SUM_END);
	localparam logic [CW-1:0] CHK_END_C = CW'(CHK_END);
	localparam logic [MW-1:0] COPY_M = MW'(COPY_BYTES);
	localparam logic [MW-1:0] TAIL_M = MW'(COPY_BYTES - 4);
	localparam logic [AWX-1:0] STORE_X = AWX'(STORE_BYTES);
	localparam logic [SW-1:0] AREA_S = SW'(AREA_LEN);
	localparam logic [WPW-1:0] WP_LIM = WPW'(COPY_BYTES - 4);

	state_t state_q, state_n;

	logic [2:0]     op_q;
	logic [AWX-1:0] addr_q;
	logic [7:0]     tag_q, len_q, data_q, rd_q;
	status_t        status_q;
	from_t          from_q;
	logic [CW-1:0]  idx_q, pos_q;
	logic [SW-1:0]  src_q;
	logic [7:0]     rtag_q;
	logic [8:0]     rlen_q, cnt_q;
	logic           beyond_q, commit_q, vcopy_q, cpdir_q, head_ok_q, tail_ok_q;
	logic           pend_q;
	logic [7:0]     ptag_q, rem_q;
	logic [WPW-1:0] wp_q, wp_inc;
	logic           m_valid_q;
	logic [15:0]    m_data_q;

	logic           mem_we, mem_re;
	logic [MW-1:0]  mem_waddr, mem_raddr;
	logic [7:0]     mem_wdata, mem_rdata;
	sum_ctrl_t      sum_ctrl;
	logic [31:0]    acc;

	logic           accept, last_byte, good, addr_ge, out_free;
	logic [CW-1:0]  left, tail_off;
	logic [SW-1:0]  scan_off;
	logic           scan_beyond;
	logic [7:0]     tag_read, len_read;
	logic [8:0]     rlen_n;
	logic           rtag_hit, del_ok, keep_ok, no_space;

	trse_store #(.DEPTH(STORE_BYTES), .AW(MW)) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	trse_sum u_sum (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (sum_ctrl),
		.acc    (acc)
	);

	assign s_tready = (state_q == S_IDLE);
	assign accept = s_tvalid & s_tready;
	assign m_tvalid = m_valid_q;
	assign m_tdata = m_data_q;
	assign out_free = !m_valid_q || m_tready;

	assign last_byte = (idx_q == COPY_C - CW'(1));
	assign good = head_ok_q & tail_ok_q & (acc == SUM_SIG);
	assign addr_ge = (addr_q >= STORE_X);
	assign left = AREA_C - pos_q;
	assign tail_off = idx_q - COPY_C + CW'(4);
	assign wp_inc = wp_q + WPW'(1);

	always_comb begin
		case (state_q)
			S_SC_TAG: scan_off = src_q + SW'(1);
			S_MV_RD:  scan_off = src_q + SW'(cnt_q);
			default:  scan_off = src_q;
		endcase
	end
	assign scan_beyond = (scan_off >= AREA_S);

	// bytes past the record area read as zero padding
	assign tag_read = beyond_q ? 8'd0 : mem_rdata;
	assign len_read = beyond_q ? 8'd0 : mem_rdata;
	assign rlen_n = {1'b0, len_read} + 9'd2;
	assign rtag_hit = (rtag_q == tag_q);
	assign del_ok = rtag_hit && (LW'(rlen_n) < LW'(left));
	assign keep_ok = !rtag_hit && (LW'(rlen_n) <= LW'(left));
	assign no_space = (len_q != 8'd0) && (LW'(left) < LW'(len_q) + LW'(2));

	// next state
	always_comb begin
		state_n = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (s_tuser) inside
						OP_RAW_WRITE, OP_RAW_READ: state_n = S_MOD;
						OP_VALIDATE:  state_n = S_V_RD;
						OP_RESET:     state_n = S_CLR;
						OP_SET_BEGIN: state_n = (s_tdata[17:10] == 8'd0) ? S_DONE : S_SC_TOP;
						OP_SET_DATA:  state_n = pend_q ? S_SD : S_DONE;
						default:      state_n = S_DONE;
					endcase
				end
			end
			S_MOD:       state_n = addr_ge ? S_MOD : S_RAW;
			S_RAW:       state_n = (op_q == OP_RAW_READ) ? S_RAW_WAIT : S_DONE;
			S_RAW_WAIT:  state_n = S_DONE;
			S_V_RD:      state_n = S_V_CHK;
			S_V_CHK:     state_n = last_byte ? S_V_DEC : S_V_RD;
			S_V_DEC: begin
				if (good) begin
					state_n = S_CP_RD;
				end else begin
					state_n = vcopy_q ? S_CLR : S_V_RD;
				end
			end
			S_CLR: begin
				if (idx_q >= AREA_C) begin
					state_n = (op_q == OP_SET_BEGIN && len_q != 8'd0) ? S_HDR0 : S_SEAL_HEAD;
				end
			end
			S_HDR0:      state_n = S_HDR1;
			S_HDR1:      state_n = S_SEAL_HEAD;
			S_SD:        state_n = S_SEAL_HEAD;
			S_SC_TOP:    state_n = (left < CW'(2)) ? S_SB_END : S_SC_TAG;
			S_SC_TAG:    state_n = (tag_read == 8'd0) ? S_SB_END : S_SC_LEN;
			S_SC_LEN: begin
				if (del_ok) begin
					state_n = S_SC_TOP;
				end else if (keep_ok) begin
					state_n = commit_q ? S_MV_RD : S_SC_TOP;
				end else begin
					state_n = S_SB_END;
				end
			end
			S_MV_RD:     state_n = S_MV_WR;
			S_MV_WR:     state_n = (cnt_q == rlen_q - 9'd1) ? S_SC_TOP : S_MV_RD;
			S_SB_END: begin
				if (commit_q) begin
					state_n = S_CLR;
				end else begin
					state_n = no_space ? S_DONE : S_SC_TOP;
				end
			end
			S_SEAL_HEAD: state_n = (idx_q == CW'(3)) ? S_SUM_RD : S_SEAL_HEAD;
			S_SUM_RD:    state_n = (idx_q < SUM_END_C) ? S_SUM_ACC : S_SEAL_SUM;
			S_SUM_ACC:   state_n = S_SUM_RD;
			S_SEAL_SUM:  state_n = (idx_q == CW'(3)) ? S_SEAL_TAIL : S_SEAL_SUM;
			S_SEAL_TAIL: state_n = (idx_q == CW'(3)) ? S_CP_RD : S_SEAL_TAIL;
			S_CP_RD:     state_n = S_CP_WR;
			S_CP_WR:     state_n = last_byte ? S_FIN : S_CP_RD;
			S_FIN:       state_n = S_DONE;
			S_DONE:      state_n = out_free ? S_IDLE : S_DONE;
			default:     state_n = S_IDLE;
		endcase
	end

	// store port and accumulator control
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re = 1'b0;
		mem_raddr = '0;
		sum_ctrl = '{op: SUM_HOLD, lane: 2'd0, data: 8'd0};
		unique case (state_q)
			S_IDLE: begin
				if (accept && s_tuser == OP_VALIDATE) begin
					sum_ctrl.op = SUM_LOAD_ZERO;
				end
			end
			S_RAW: begin
				mem_raddr = MW'(addr_q);
				mem_waddr = MW'(addr_q);
				mem_wdata = data_q;
				mem_re = (op_q == OP_RAW_READ);
				mem_we = (op_q == OP_RAW_WRITE);
			end
			S_V_RD: begin
				mem_re = 1'b1;
				mem_raddr = MW'(idx_q) + (vcopy_q ? COPY_M : MW'(0));
			end
			S_V_CHK: begin
				if (idx_q >= CW'(4) && idx_q < CHK_END_C) begin
					sum_ctrl = '{op: SUM_ADD, lane: idx_q[1:0], data: mem_rdata};
				end
			end
			S_V_DEC: begin
				if (!good && !vcopy_q) begin
					sum_ctrl.op = SUM_LOAD_ZERO;
				end
			end
			S_CLR: begin
				mem_we = (idx_q < AREA_C);
				mem_waddr = MW'(idx_q) + MW'(8);
			end
			S_HDR0: begin
				mem_we = 1'b1;
				mem_waddr = MW'(pos_q) + MW'(8);
				mem_wdata = tag_q;
			end
			S_HDR1: begin
				mem_we = 1'b1;
				mem_waddr = MW'(pos_q) + MW'(9);
				mem_wdata = len_q;
			end
			S_SD: begin
				mem_we = (wp_q < WP_LIM);
				mem_waddr = MW'(wp_q);
				mem_wdata = data_q;
			end
			S_SC_TOP, S_SC_TAG, S_MV_RD: begin
				mem_re = 1'b1;
				mem_raddr = MW'(scan_off) + MW'(8);
			end
			S_MV_WR: begin
				mem_we = 1'b1;
				mem_waddr = MW'(pos_q) + MW'(cnt_q) + MW'(8);
				mem_wdata = beyond_q ? 8'd0 : mem_rdata;
			end
			S_SEAL_HEAD: begin
				mem_we = 1'b1;
				mem_waddr = MW'(idx_q);
				mem_wdata = sig_byte(HEAD_SIG, idx_q[1:0]);
				sum_ctrl.op = SUM_LOAD_SIG;
			end
			S_SUM_RD: begin
				mem_re = 1'b1;
				mem_raddr = MW'(idx_q);
			end
			S_SUM_ACC: begin
				sum_ctrl = '{op: SUM_SUB, lane: idx_q[1:0], data: mem_rdata};
			end
			S_SEAL_SUM: begin
				mem_we = 1'b1;
				mem_waddr = MW'(idx_q) + MW'(4);
				mem_wdata = sig_byte(acc, idx_q[1:0]);
			end
			S_SEAL_TAIL: begin
				mem_we = 1'b1;
				mem_waddr = TAIL_M + MW'(idx_q);
				mem_wdata = sig_byte(TAIL_SIG, idx_q[1:0]);
			end
			S_CP_RD: begin
				mem_re = 1'b1;
				mem_raddr = MW'(idx_q) + (cpdir_q ? COPY_M : MW'(0));
			end
			S_CP_WR: begin
				mem_we = 1'b1;
				mem_waddr = MW'(idx_q) + (cpdir_q ? MW'(0) : COPY_M);
				mem_wdata = mem_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			m_valid_q <= 1'b0;
			pend_q <= 1'b0;
			ptag_q <= '0;
			rem_q <= '0;
			wp_q <= '0;
			pos_q <= '0;
			src_q <= '0;
			commit_q <= 1'b0;
			vcopy_q <= 1'b0;
			cpdir_q <= 1'b0;
			idx_q <= '0;
		end else begin
			state_q <= state_n;
			// a new result replaces the one leaving in the same cycle
			if (state_q == S_DONE && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q <= '0;
						vcopy_q <= 1'b0;
						commit_q <= 1'b0;
						pos_q <= '0;
						src_q <= '0;
					end
				end
				S_V_CHK: begin
					if (!last_byte) begin
						idx_q <= idx_q + CW'(1);
					end
				end
				S_V_DEC: begin
					idx_q <= '0;
					if (good) begin
						cpdir_q <= vcopy_q;
					end else begin
						vcopy_q <= 1'b1;
					end
				end
				S_CLR: begin
					if (idx_q < AREA_C) begin
						idx_q <= idx_q + CW'(1);
					end else begin
						idx_q <= '0;
					end
				end
				S_HDR1, S_SD: idx_q <= '0;
				S_SC_LEN: begin
					if (del_ok) begin
						src_q <= src_q + SW'(rlen_n);
					end else if (keep_ok && !commit_q) begin
						pos_q <= pos_q + CW'(rlen_n);
						src_q <= src_q + SW'(rlen_n);
					end
				end
				S_MV_WR: begin
					if (cnt_q == rlen_q - 9'd1) begin
						pos_q <= pos_q + CW'(rlen_q);
						src_q <= src_q + SW'(rlen_q);
					end
				end
				S_SB_END: begin
					if (commit_q) begin
						idx_q <= pos_q;
					end else if (!no_space) begin
						commit_q <= 1'b1;
						pos_q <= '0;
						src_q <= '0;
					end
				end
				S_SEAL_HEAD: idx_q <= (idx_q == CW'(3)) ? CW'(8) : idx_q + CW'(1);
				S_SUM_RD: begin
					if (idx_q >= SUM_END_C) begin
						idx_q <= '0;
					end
				end
				S_SUM_ACC: idx_q <= idx_q + CW'(1);
				S_SEAL_SUM: idx_q <= (idx_q == CW'(3)) ? CW'(0) : idx_q + CW'(1);
				S_SEAL_TAIL: begin
					idx_q <= (idx_q == CW'(3)) ? CW'(0) : idx_q + CW'(1);
					cpdir_q <= 1'b0;
				end
				S_CP_WR: idx_q <= idx_q + CW'(1);
				S_FIN: begin
					case (op_q)
						OP_SET_BEGIN: begin
							pend_q <= (len_q != 8'd0);
							ptag_q <= (len_q != 8'd0) ? tag_q : 8'd0;
							rem_q <= len_q;
							wp_q <= (len_q != 8'd0) ? WPW'(pos_q) + WPW'(10) : '0;
						end
						OP_SET_DATA: begin
							wp_q <= WPW'(wp_inc[9:0]);
							rem_q <= rem_q - 8'd1;
							if (rem_q == 8'd1) begin
								pend_q <= 1'b0;
							end
						end
						default: begin
							pend_q <= 1'b0;
							rem_q <= '0;
						end
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q <= s_tuser;
					addr_q <= AWX'(s_tdata[9:0]);
					tag_q <= s_tdata[17:10];
					len_q <= s_tdata[25:18];
					data_q <= s_tdata[33:26];
					rd_q <= '0;
					from_q <= FROM_FIRST;
					head_ok_q <= 1'b1;
					tail_ok_q <= 1'b1;
					case (s_tuser) inside
						OP_RAW_WRITE, OP_RAW_READ, OP_VALIDATE, OP_RESET: status_q <= ST_OK;
						OP_SET_BEGIN:
							status_q <= (s_tdata[17:10] == 8'd0) ? ST_BAD_TAG : ST_OK;
						OP_SET_DATA: status_q <= pend_q ? ST_OK : ST_SEQ_ERR;
						default: status_q <= ST_SEQ_ERR;
					endcase
				end
			end
			S_MOD: begin
				if (addr_ge) begin
					addr_q <= addr_q - STORE_X;
				end
			end
			S_RAW_WAIT: rd_q <= mem_rdata;
			S_V_CHK: begin
				if (idx_q < CW'(4) && mem_rdata != sig_byte(HEAD_SIG, idx_q[1:0])) begin
					head_ok_q <= 1'b0;
				end
				if (idx_q >= COPY_C - CW'(4)
						&& mem_rdata != sig_byte(TAIL_SIG, tail_off[1:0])) begin
					tail_ok_q <= 1'b0;
				end
			end
			S_V_DEC: begin
				head_ok_q <= 1'b1;
				tail_ok_q <= 1'b1;
				if (good) begin
					from_q <= vcopy_q ? FROM_SECOND : FROM_FIRST;
				end else if (vcopy_q) begin
					status_q <= ST_EMPTIED;
					from_q <= FROM_NONE;
				end
			end
			S_SC_TOP: beyond_q <= scan_beyond;
			S_SC_TAG: begin
				rtag_q <= tag_read;
				beyond_q <= scan_beyond;
			end
			S_SC_LEN: begin
				rlen_q <= rlen_n;
				cnt_q <= '0;
			end
			S_MV_RD: beyond_q <= scan_beyond;
			S_MV_WR: cnt_q <= cnt_q + 9'd1;
			S_SB_END: begin
				if (!commit_q && no_space) begin
					status_q <= ST_NO_SPACE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					m_data_q <= {3'b000, from_q, status_q, rd_q};
				end
			end
			default: begin
			end
		endcase
	end

	a_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (ptag_q != 8'd0 && rem_q != 8'd0))
		else $error("pending set without tag or payload count");

	a_compact_order: assert property (@(posedge clk) disable iff (!arst_n)
		SW'(pos_q) <= src_q)
		else $error("compaction write pointer ran ahead of read pointer");

	a_move_in_area: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MV_WR) |-> (mem_waddr < TAIL_M))
		else $error("record move left the first copy's record area");

	a_from_validate: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && op_q != OP_VALIDATE) |-> (from_q == FROM_FIRST))
		else $error("repair source reported for a non-validate word");
endmodule
`default_nettype wire
